### rtl/ptps_pkg.sv
// Shared constants, lookup tables and table builders for the pan/tilt pointing step.
`timescale 1ns / 1ps
package ptps_pkg;

    // Field widths of the ports
    localparam int ERR_W   = 32;
    localparam int YAW_W   = 25;
    localparam int PITCH_W = 24;
    localparam int DT_W    = 20;
    localparam int DIST_W  = 24;
    localparam int SPEED_W = 8;

    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // Speed register
    localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd50;
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 8'd10;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 8'd100;

    // Frame time limits in microseconds
    localparam logic [16:0] DT_DEFAULT = 17'd16667;
    localparam logic [16:0] DT_LIMIT   = 17'd100000;

    // t = lg * dt * 3 / 50000, quotient estimate by reciprocal of 2^44 / 50000
    localparam logic [15:0] T_DIV   = 16'd50000;
    localparam logic [28:0] T_RECIP = 29'd351843720;

    // Reciprocal 2^32 / 360 rounded up, for whole turns of degrees
    localparam logic [24:0] WRAP_RECIP = 25'd11930465;

    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam logic [30:0] SHARE_MIN = 31'd21474836;
    localparam logic [63:0] DEAD_NUM  = 64'd1718873385;

    localparam int LG_W   = 19;
    localparam int LG_N   = 90;
    localparam int ROOT_N = 16;

    typedef logic [LG_N-1:0][LG_W-1:0] t_lg_tab;
    typedef logic [ROOT_N-1:0][29:0]   t_root_tab;

    // Restoring long division, one quotient bit per step
    function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Integer square root, two bits per step
    function automatic logic [63:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = xin;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2(180 / n) in Q16 by repeated squaring of the Q30 mantissa
    function automatic logic [LG_W-1:0] calc_lg(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] m;
        logic [15:0] fr;
        int b;
        int k;
        r = div64(64'd180 << 30, n);
        b = 0;
        for (int j = 0; j < 64; j++) begin
            if (r[j]) b = j;
        end
        k  = b - 30;
        m  = r >> k;
        fr = '0;
        for (int i = 0; i < 16; i++) begin
            m  = (m * m) >> 30;
            fr = {fr[14:0], 1'b0};
            if (m >= (64'd2 << 30)) begin
                fr[0] = 1'b1;
                m     = m >> 1;
            end
        end
        return {3'(k), fr};
    endfunction

    // Entry i holds the log for speed 10 + i
    function automatic t_lg_tab build_lg_tab();
        t_lg_tab tab;
        for (int i = 0; i < LG_N; i++) begin
            tab[i] = calc_lg(64'(LG_N - i));
        end
        return tab;
    endfunction

    // Entry i holds 2^(-2^-(i+1)) in Q30
    function automatic t_root_tab build_root_tab();
        t_root_tab   tab;
        logic [63:0] root;
        root = isqrt64(64'd1 << 59);
        tab[0] = root[29:0];
        for (int i = 1; i < ROOT_N; i++) begin
            root   = isqrt64(root << 30);
            tab[i] = root[29:0];
        end
        return tab;
    endfunction

    localparam t_lg_tab   LG_TAB   = build_lg_tab();
    localparam t_root_tab ROOT_TAB = build_root_tab();

endpackage

### rtl/ptps_wrap.sv
// Two-stage wrap of a signed fixed-point angle into +-180 degrees.
`timescale 1ns / 1ps
module ptps_wrap #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_a,
    output logic signed [F+9:0] o_y
);
    import ptps_pkg::*;

    localparam int NW = 26;
    localparam int QW = 20;
    localparam logic [F+9:0] HALF = (F+10)'(180) << F;
    localparam logic [F+9:0] TURN = (F+10)'(360) << F;

    logic signed [W-1:0]  r_a;
    logic signed [QW-1:0] r_q;
    logic signed [F+9:0]  r_y;
    logic signed [F+9:0]  n_y;
    logic signed [NW-1:0] deg_in;
    logic signed [NW-1:0] deg_r;
    logic signed [50:0]   prod;
    logic signed [31:0]   remw;
    logic signed [31:0]   remc;
    logic [F+8:0]         m;
    logic [F+9:0]         mx;

    // Estimate whole turns from the integer degrees
    assign deg_in = NW'(i_a >>> F);
    assign prod   = deg_in * $signed({1'b0, WRAP_RECIP});

    // Correct the remainder and fold into +-180 degrees; a half turn keeps the sign of the input
    always_comb begin
        deg_r = NW'(r_a >>> F);
        remw  = 32'(deg_r) - 32'(r_q) * 32'sd360;
        if (remw < 0) begin
            remc = remw + 32'sd360;
        end else if (remw >= 32'sd360) begin
            remc = remw - 32'sd360;
        end else begin
            remc = remw;
        end
        m  = {remc[8:0], r_a[F-1:0]};
        mx = {1'b0, m};
        if (mx > HALF) begin
            n_y = $signed(mx - TURN);
        end else if (mx == HALF) begin
            n_y = r_a[W-1] ? $signed(-HALF) : $signed(HALF);
        end else begin
            n_y = $signed(mx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= i_a;
            r_q <= QW'(prod >>> 32);
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

### rtl/pan_tilt_pointing_step_top.sv
// Pan/tilt pointing step: dead zone, fps-independent gain and angle update.
// Each accepted word passes through the stage registers and then the output register.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// The 16-stage power-of-two product chain sets the depth.
// Reset clears the valid bits and loads the speed register with 50.
`timescale 1ns / 1ps
module pan_tilt_pointing_step_top #(
    parameter int ANGLE_FRAC_BITS = ptps_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_target_valid,
    input  logic signed [ptps_pkg::ERR_W-1:0]   i_err_yaw,
    input  logic signed [ptps_pkg::ERR_W-1:0]   i_err_pitch,
    input  logic signed [ptps_pkg::YAW_W-1:0]   i_yaw_now,
    input  logic signed [ptps_pkg::PITCH_W-1:0] i_pitch_now,
    input  logic [ptps_pkg::DT_W-1:0]           i_dt_us,
    input  logic [ptps_pkg::DIST_W-1:0]         i_dist_mm,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_write_valid,
    output logic signed [ptps_pkg::YAW_W-1:0]   o_new_yaw,
    output logic signed [ptps_pkg::PITCH_W-1:0] o_new_pitch,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptps_pkg::SPEED_W-1:0]        i_cfg_speed_tenths
);
    import ptps_pkg::*;

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int SW = F + 6;
    localparam int YW = ((F + 6 > YAW_W) ? F + 6 : YAW_W) + 1;

    localparam logic [63:0] DZ_C   = (DEAD_NUM << F) / 64'd1000000;
    localparam logic [63:0] DZ_MIN = (64'd5 << F) / 64'd100;
    localparam int          WDB    = $clog2(DZ_C / 64'd1001 + 64'd1);
    localparam int          PW     = WDB + 1 + DIST_W;
    localparam logic [33:0] SAT34  = 34'(1) << WDB;

    localparam logic signed [33:0] STEP_LIM  = 34'(12) << F;
    localparam logic signed [33:0] PITCH_LIM = 34'(89) << F;
    localparam logic signed [33:0] HALF34    = 34'(180) << F;

    // Stage indices
    localparam int S_X     = 1;
    localparam int S_Q     = 2;
    localparam int S_T     = 3;
    localparam int S_PROD  = 4;
    localparam int S_SHARE = S_PROD + ROOT_N;
    localparam int S_MAG   = S_SHARE + 1;
    localparam int S_STEP  = S_MAG + 1;
    localparam int S_SMALL = S_STEP + 1;
    localparam int S_WR    = S_SMALL + 1;
    localparam int S_NY    = S_WR + 1;
    localparam int NST     = S_NY + 1;

    typedef struct packed {
        logic                      tv;
        logic signed [33:0]        ey;
        logic signed [33:0]        ep;
        logic signed [YAW_W-1:0]   yn;
        logic signed [PITCH_W-1:0] pn;
        logic [DIST_W-1:0]         dmm;
        logic                      far;
        logic [LG_W-1:0]           lg;
        logic                      n0;
        logic [18:0]               dt3;
        logic [37:0]               x;
        logic [22:0]               q0;
        logic [22:0]               t;
        logic [PW-1:0]             ppy;
        logic [PW-1:0]             ppp;
        logic                      d0y;
        logic                      d0p;
        logic                      in1;
        logic [30:0]               p;
        logic [30:0]               share;
        logic [62:0]               my;
        logic [62:0]               mp;
        logic signed [SW-1:0]      sy;
        logic signed [SW-1:0]      sp;
        logic [PW-1:0]             qy;
        logic [PW-1:0]             qp;
        logic                      s0y;
        logic                      s0p;
        logic signed [YW-1:0]      yw;
        logic signed [PITCH_W-1:0] np;
        logic                      wr;
    } t_stage;

    t_stage                    r_p [NST];
    t_stage                    n_p [NST];
    logic [NST-1:0]            r_vld;
    logic [SPEED_W-1:0]        r_speed;
    logic                      r_out_vld;
    logic                      r_out_wr;
    logic signed [YAW_W-1:0]   r_out_yaw;
    logic signed [PITCH_W-1:0] r_out_pitch;
    logic                      en;
    logic signed [F+9:0]       ey_wrap;
    logic signed [F+9:0]       ny_wrap;
    logic signed [33:0]        ny_ext;

    function automatic logic [33:0] mag34(input logic signed [33:0] e);
        return e[33] ? 34'(-e) : 34'(e);
    endfunction

    // (min(a, 2^WDB) + 1) * dist, compared against the dead-zone numerator
    function automatic logic [PW-1:0] dz_prod(input logic [33:0] a,
                                              input logic [DIST_W-1:0] d);
        logic [WDB:0] s;
        logic [WDB:0] s1;
        s  = (a >= SAT34) ? SAT34[WDB:0] : a[WDB:0];
        s1 = s + 1'b1;
        return PW'(s1 * d);
    endfunction

    // Advance whenever the output register is free or being taken
    assign en          = !(r_out_vld && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    ptps_wrap #(.W(ERR_W), .F(F)) u_wrap_err (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_err_yaw),
        .o_y   (ey_wrap)
    );

    ptps_wrap #(.W(YW), .F(F)) u_wrap_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_p[S_SMALL].yw),
        .o_y   (ny_wrap)
    );

    assign ny_ext = 34'(ny_wrap);

    always_comb begin
        logic [16:0]        dts;
        logic [6:0]         sc;
        logic [6:0]         idx;
        logic [39:0]        rem;
        logic [60:0]        prod;
        logic [6:0]         ti;
        logic [30:0]        psh;
        logic [30:0]        sh;
        logic [63:0]        vy;
        logic [63:0]        vp;
        logic [33:0]        cy;
        logic [33:0]        cp;
        logic signed [33:0] psum;
        logic               lt_y;
        logic               lt_p;
        logic               tiny;

        // Capture the word, sanitize frame time, look up the speed log
        n_p[0]      = '0;
        n_p[0].tv   = i_target_valid;
        n_p[0].ep   = 34'(i_err_pitch);
        n_p[0].yn   = i_yaw_now;
        n_p[0].pn   = i_pitch_now;
        n_p[0].dmm  = i_dist_mm;
        n_p[0].far  = i_dist_mm > DIST_W'(1000);
        if (i_dt_us == '0) begin
            dts = DT_DEFAULT;
        end else if (i_dt_us > DT_W'(DT_LIMIT)) begin
            dts = DT_LIMIT;
        end else begin
            dts = i_dt_us[16:0];
        end
        n_p[0].dt3 = 19'(dts) + (19'(dts) << 1);
        if (r_speed < SPEED_MIN) begin
            sc = SPEED_MIN[6:0];
        end else if (r_speed > SPEED_MAX) begin
            sc = SPEED_MAX[6:0];
        end else begin
            sc = r_speed[6:0];
        end
        n_p[0].n0 = (sc == SPEED_MAX[6:0]);
        idx       = n_p[0].n0 ? 7'd0 : 7'(sc - SPEED_MIN[6:0]);
        n_p[0].lg = LG_TAB[idx];

        for (int k = 1; k < NST; k++) begin
            n_p[k] = r_p[k-1];
        end

        // Exponent product and pitch dead-zone product
        n_p[S_X].x   = 38'(r_p[S_X-1].lg * r_p[S_X-1].dt3);
        n_p[S_X].ppp = dz_prod(mag34(r_p[S_X-1].ep), r_p[S_X-1].dmm);
        n_p[S_X].d0p = mag34(r_p[S_X-1].ep) < DZ_MIN[33:0];

        // Quotient estimate; take the wrapped yaw error
        n_p[S_Q].q0  = 23'((53'(r_p[S_Q-1].x >> 14) * 53'(T_RECIP)) >> 30);
        n_p[S_Q].ey  = 34'(ey_wrap);
        n_p[S_Q].ppy = dz_prod(mag34(n_p[S_Q].ey), r_p[S_Q-1].dmm);
        n_p[S_Q].d0y = mag34(n_p[S_Q].ey) < DZ_MIN[33:0];

        // Correct the quotient, decide the offset dead zone
        rem = 40'(r_p[S_T-1].x) - 40'(r_p[S_T-1].q0) * 40'(T_DIV);
        n_p[S_T].t = (rem >= 40'(T_DIV)) ? r_p[S_T-1].q0 + 23'd1 : r_p[S_T-1].q0;
        lt_y = r_p[S_T-1].d0y || (r_p[S_T-1].far && 64'(r_p[S_T-1].ppy) <= DZ_C);
        lt_p = r_p[S_T-1].d0p || (r_p[S_T-1].far && 64'(r_p[S_T-1].ppp) <= DZ_C);
        n_p[S_T].in1 = lt_y && lt_p;
        n_p[S_T].p   = Q30_ONE;

        // Multiply in one root per fraction bit of t, most significant first
        for (int i = 0; i < ROOT_N; i++) begin
            prod = r_p[S_PROD+i-1].p * ROOT_TAB[i];
            if (r_p[S_PROD+i-1].t[15-i]) begin
                n_p[S_PROD+i].p = 31'(prod >> 30);
            end
        end

        // Shift by the integer part, form the share with its floor
        ti = r_p[S_SHARE-1].t[22:16];
        if (ti >= 7'd31) begin
            psh = '0;
        end else begin
            psh = r_p[S_SHARE-1].p >> ti[4:0];
        end
        sh = Q30_ONE - psh;
        if (r_p[S_SHARE-1].n0) begin
            n_p[S_SHARE].share = Q30_ONE;
        end else begin
            n_p[S_SHARE].share = (sh < SHARE_MIN) ? SHARE_MIN : sh;
        end

        // Scale offset magnitudes by the share
        n_p[S_MAG].my = 63'(mag34(r_p[S_MAG-1].ey)) * 63'(r_p[S_MAG-1].share);
        n_p[S_MAG].mp = 63'(mag34(r_p[S_MAG-1].ep)) * 63'(r_p[S_MAG-1].share);

        // Round half away from zero, saturate, restore the sign
        vy = (64'(r_p[S_STEP-1].my) + (64'd1 << 29)) >> 30;
        vp = (64'(r_p[S_STEP-1].mp) + (64'd1 << 29)) >> 30;
        cy = (vy > 64'(STEP_LIM)) ? STEP_LIM : vy[33:0];
        cp = (vp > 64'(STEP_LIM)) ? STEP_LIM : vp[33:0];
        n_p[S_STEP].sy = r_p[S_STEP-1].ey[33] ? SW'(-$signed(cy)) : SW'($signed(cy));
        n_p[S_STEP].sp = r_p[S_STEP-1].ep[33] ? SW'(-$signed(cp)) : SW'($signed(cp));

        // Tiny-step products and the raw new angles
        n_p[S_SMALL].qy  = dz_prod(mag34(34'(r_p[S_SMALL-1].sy)) << 2, r_p[S_SMALL-1].dmm);
        n_p[S_SMALL].qp  = dz_prod(mag34(34'(r_p[S_SMALL-1].sp)) << 2, r_p[S_SMALL-1].dmm);
        n_p[S_SMALL].s0y = (mag34(34'(r_p[S_SMALL-1].sy)) << 2) < DZ_MIN[33:0];
        n_p[S_SMALL].s0p = (mag34(34'(r_p[S_SMALL-1].sp)) << 2) < DZ_MIN[33:0];
        n_p[S_SMALL].yw  = YW'(r_p[S_SMALL-1].yn) + YW'(r_p[S_SMALL-1].sy);
        psum = 34'(r_p[S_SMALL-1].pn) + 34'(r_p[S_SMALL-1].sp);
        if (psum > PITCH_LIM) begin
            psum = PITCH_LIM;
        end else if (psum < -PITCH_LIM) begin
            psum = -PITCH_LIM;
        end
        n_p[S_SMALL].np = psum[PITCH_W-1:0];

        // Decide whether to write
        tiny = (r_p[S_WR-1].s0y || (r_p[S_WR-1].far && 64'(r_p[S_WR-1].qy) <= DZ_C)) &&
               (r_p[S_WR-1].s0p || (r_p[S_WR-1].far && 64'(r_p[S_WR-1].qp) <= DZ_C));
        n_p[S_WR].wr = r_p[S_WR-1].tv && !r_p[S_WR-1].in1 && !tiny;
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // Output register; fields are zero when nothing is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[S_NY];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_wr    <= r_p[S_NY].wr;
            r_out_yaw   <= r_p[S_NY].wr ? ny_ext[YAW_W-1:0] : '0;
            r_out_pitch <= r_p[S_NY].wr ? r_p[S_NY].np : '0;
        end
    end

    // Speed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_speed <= i_cfg_speed_tenths;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_write_valid = r_out_wr;
    assign o_new_yaw     = r_out_yaw;
    assign o_new_pitch   = r_out_pitch;

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_wr) |-> (r_out_yaw == '0 && r_out_pitch == '0))
        else $error("no-write word carries nonzero angles");

    a_yaw_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[S_NY] && r_p[S_NY].wr) |-> (ny_ext <= HALF34 && ny_ext >= -HALF34))
        else $error("wrapped yaw outside half turn");

    a_share_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_MAG] |-> (r_p[S_MAG].share >= SHARE_MIN && r_p[S_MAG].share <= Q30_ONE))
        else $error("share outside its floor and one");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved under output stall");

endmodule

### test/ptps_checker.sv
// Checker for the pan/tilt pointing step: predicts each result word and compares it.
`timescale 1ns / 1ps
module ptps_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic                                i_target_valid,
    input  logic signed [ptps_pkg::ERR_W-1:0]   i_err_yaw,
    input  logic signed [ptps_pkg::ERR_W-1:0]   i_err_pitch,
    input  logic signed [ptps_pkg::YAW_W-1:0]   i_yaw_now,
    input  logic signed [ptps_pkg::PITCH_W-1:0] i_pitch_now,
    input  logic [ptps_pkg::DT_W-1:0]           i_dt_us,
    input  logic [ptps_pkg::DIST_W-1:0]         i_dist_mm,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic                                o_write_valid,
    input  logic signed [ptps_pkg::YAW_W-1:0]   o_new_yaw,
    input  logic signed [ptps_pkg::PITCH_W-1:0] o_new_pitch,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [ptps_pkg::SPEED_W-1:0]        i_cfg_speed_tenths,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_written
);
    import ptps_pkg::*;

    localparam int FB = ANGLE_FRAC_BITS_DEF;

    typedef struct packed {
        logic                      write_valid;
        logic signed [YAW_W-1:0]   new_yaw;
        logic signed [PITCH_W-1:0] new_pitch;
    } t_pointing;

    t_pointing       pointing_q[$];
    logic [SPEED_W-1:0] speed_reg;

    function automatic longint wrap_deg(longint a);
        longint h, r;
        h = longint'(180) << FB;
        r = longint'(360) << FB;
        if (a > h) a -= ((a - h + r - 1) / r) * r;
        else if (a < -h) a += ((-h - a + r - 1) / r) * r;
        return a;
    endfunction

    function automatic longint clip(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] sqrt_floor(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Gain in Q30: 1 - q^(60 dt), floored at 0.02
    function automatic logic [63:0] gain_q30(int s, logic [63:0] dt);
        logic [63:0] n, r, m, lg, t, p, root;
        int b, k;
        n = 100 - s;
        if (n == 0) return 64'd1 << 30;
        r = (64'd180 << 30) / n;
        b = 0;
        while ((r >> (b + 1)) != 0) b++;
        k = b - 30;
        m = r >> k;
        lg = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            lg = lg << 1;
            if (m >= (64'd2 << 30)) begin
                lg |= 1;
                m >>= 1;
            end
        end
        lg |= 64'(k) << 16;
        t = lg * dt * 60 / 1000000;
        p = 64'd1 << 30;
        root = p;
        for (int i = 1; i <= 16; i++) begin
            root = (i == 1) ? sqrt_floor(64'd1 << 59) : sqrt_floor(root << 30);
            if ((t >> (16 - i)) & 1) p = (p * root) >> 30;
        end
        if ((t >> 16) >= 31) p = 0;
        else p = p >> (t >> 16);
        p = (64'd1 << 30) - p;
        return p < 64'(SHARE_MIN) ? 64'(SHARE_MIN) : p;
    endfunction

    function automatic longint scaled_step(longint e, logic [63:0] g);
        logic [63:0] mg;
        longint v;
        mg = 64'(mag(e)) * g;
        v = longint'((mg + (64'd1 << 29)) >> 30);
        return e < 0 ? -v : v;
    endfunction

    function automatic t_pointing predict_pointing(logic tv, logic signed [ERR_W-1:0] eyi,
            logic signed [ERR_W-1:0] epi, logic signed [YAW_W-1:0] yni,
            logic signed [PITCH_W-1:0] pni, logic [DT_W-1:0] dti, logic [DIST_W-1:0] dsi,
            logic [SPEED_W-1:0] spd);
        t_pointing res;
        longint ey, ep, dead, wd, sy, sp;
        logic [63:0] dt, g;
        int s;
        res = '0;
        if (!tv) return res;
        ey = wrap_deg(longint'(eyi));
        ep = longint'(epi);
        dt = 64'(dti);
        if (dt == 0) dt = 16667;
        if (dt > 100000) dt = 100000;
        s = int'(spd);
        if (s < 10) s = 10;
        if (s > 100) s = 100;
        dead = (longint'(5) << FB) / 100;
        if (dsi > 1000) begin
            wd = longint'((DEAD_NUM << FB) / (64'(dsi) * 64'd1000000));
            if (wd > dead) dead = wd;
        end
        if (mag(ey) < dead && mag(ep) < dead) return res;
        g = gain_q30(s, dt);
        sy = clip(scaled_step(ey, g), longint'(12) << FB);
        sp = clip(scaled_step(ep, g), longint'(12) << FB);
        if (4 * mag(sy) < dead && 4 * mag(sp) < dead) return res;
        res.write_valid = 1'b1;
        res.new_yaw = YAW_W'(wrap_deg(longint'(yni) + sy));
        res.new_pitch = PITCH_W'(clip(longint'(pni) + sp, longint'(89) << FB));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_written = 0;
    end

    assign o_pending = pointing_q.size();

    always @(posedge i_clk) begin
        t_pointing want;
        if (!i_rst_n) begin
            speed_reg <= SPEED_RESET;
        end else begin
            // track the speed register
            if (i_cfg_valid && o_cfg_ready) speed_reg <= i_cfg_speed_tenths;
            // predict each accepted word
            if (i_valid && !o_stall)
                pointing_q.push_back(predict_pointing(i_target_valid, i_err_yaw, i_err_pitch,
                    i_yaw_now, i_pitch_now, i_dt_us, i_dist_mm, speed_reg));
            // compare each delivered word with the oldest prediction
            if (o_valid && !i_stall) begin
                if (pointing_q.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    want = pointing_q.pop_front();
                    if (o_write_valid) o_written++;
                    if (o_write_valid !== want.write_valid)
                        report_mismatch("write_valid", o_write_valid, want.write_valid);
                    if (o_new_yaw !== want.new_yaw)
                        report_mismatch("new_yaw", o_new_yaw, want.new_yaw);
                    if (o_new_pitch !== want.new_pitch)
                        report_mismatch("new_pitch", o_new_pitch, want.new_pitch);
                end
            end
        end
    end
endmodule

### test/tb.sv
// Testbench top for the pan/tilt pointing step: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
    import ptps_pkg::*;

    localparam int LATENCY = 26;
    localparam int WATCHDOG_LIMIT = 2000;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, o_stall, o_valid, i_stall = 0;
    logic i_target_valid = 0;
    logic signed [ERR_W-1:0] i_err_yaw = 0, i_err_pitch = 0;
    logic signed [YAW_W-1:0] i_yaw_now = 0;
    logic signed [PITCH_W-1:0] i_pitch_now = 0;
    logic [DT_W-1:0] i_dt_us = 0;
    logic [DIST_W-1:0] i_dist_mm = 0;
    logic o_write_valid;
    logic signed [YAW_W-1:0] o_new_yaw;
    logic signed [PITCH_W-1:0] o_new_pitch;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [SPEED_W-1:0] i_cfg_speed_tenths = 0;
    int fail_count, pending, written;
    int idle_cycles = 0;
    bit calm = 0;
    bit hold_output = 0;

    always #4 i_clk = ~i_clk;

    pan_tilt_pointing_step_top i_dut (.*);

    ptps_checker i_chk (.*, .o_fail_count(fail_count), .o_pending(pending),
        .o_written(written));

    // Receiver stall: random bursts, one long hold on request, none when calm
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_output) begin
                i_stall <= 1;
                repeat (120) @(negedge i_clk);
                hold_output = 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 7);
                i_stall <= 1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_stall <= 0;
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_speed(logic [SPEED_W-1:0] s);
        i_cfg_valid <= 1;
        i_cfg_speed_tenths <= s;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_pipe();
        i_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // Offer one word and hold it until accepted; random gaps before it
    task automatic send_pointing(logic tv, logic [31:0] ey, logic [31:0] ep,
            logic [YAW_W-1:0] yn, logic [PITCH_W-1:0] pn, logic [DT_W-1:0] dt,
            logic [DIST_W-1:0] ds);
        if (!calm && $urandom_range(0, 9) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid <= 1;
        i_target_valid <= tv;
        i_err_yaw <= ey;
        i_err_pitch <= ep;
        i_yaw_now <= yn;
        i_pitch_now <= pn;
        i_dt_us <= dt;
        i_dist_mm <= ds;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_err();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
            2: return 32'($signed($urandom_range(0, 1600 * 65536)) - 800 * 65536);
            3: return 32'($signed($urandom_range(0, 8000)) - 4000);
            default: return 32'($signed($urandom_range(0, 60 * 65536)) - 30 * 65536);
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return DT_W'($urandom());
            2: return DT_W'($urandom_range(90000, 110000));
            default: return DT_W'($urandom_range(1, 40000));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 3))
            0: return DIST_W'($urandom());
            1: return DIST_W'($urandom_range(900, 1100));
            default: return DIST_W'($urandom_range(0, 50000));
        endcase
    endfunction

    task automatic random_pointing();
        send_pointing($urandom_range(0, 7) != 0, pick_err(), pick_err(),
            25'($signed($urandom_range(0, 23592960)) - 11796480),
            24'($signed($urandom_range(0, 11796480)) - 5898240),
            pick_dt(), pick_dist());
    endtask

    initial begin
        logic [SPEED_W-1:0] speeds[6];
        speeds = '{8'd0, 8'd10, 8'd255, 8'd100, 8'd99, 8'd73};
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed words at reset speed
        send_pointing(0, 32'd65536 * 20, 0, 0, 0, 0, 0);
        send_pointing(1, 32'h8000_0000, 32'h7fff_ffff, 25'sd11796480, -24'sd5898240, 0, 0);
        send_pointing(1, 32'h7fff_ffff, 32'h8000_0000, -25'sd11796480, 24'sd5898240,
            20'hfffff, 24'hffffff);
        send_pointing(1, 32'd1000, -32'sd1000, 0, 0, 16667, 500);
        send_pointing(1, 32'd4000, 0, 0, 0, 1, 1001);
        send_pointing(1, 32'd65536 * 179, 0, 25'sd11796480, 0, 100000, 2000);
        send_pointing(1, -32'sd65536 * 200, 32'd65536 * 100, 0, 24'sd5832704, 100001, 1000);
        send_pointing(1, 32'd65536 * 361, -32'sd65536 * 50, -25'sd11000000, -24'sd5800000,
            1, 16777215);
        send_pointing(1, 32'd3300, 32'd3300, 0, 0, 16667, 0);
        send_pointing(1, 32'd13000, 0, 0, 0, 100, 0);

        // phases over speed settings; long output hold then full drain
        for (int ph = 0; ph < 7; ph++) begin
            drain_pipe();
            write_speed(ph < 6 ? speeds[ph] : 8'($urandom()));
            if (ph == 2) hold_output = 1;
            if (ph == 6) calm = 1;
            for (int i = 0; i < 180; i++) random_pointing();
        end

        drain_pipe();
        $display("covered 1270 words over seven speed settings, %0d angle writes",
            written);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/ptps_pkg.sv
rtl/ptps_wrap.sv
rtl/pan_tilt_pointing_step_top.sv
test/ptps_checker.sv
test/tb.sv
